[rtl/lgpf_pkg.sv]
package lgpf_pkg;

	localparam int COEF_WIDTH_DEF    = 32;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ANGLE_WIDTH       = 16;
	localparam int DIST_WIDTH        = 32;
	localparam int FRAC_BITS         = 16;
	localparam int ATAN_DEPTH        = 24;

	// Arctangent of 2^-i, 2^31 equals pi
	function automatic logic [31:0] atan_lut(input logic [4:0] idx);
		logic [31:0] v;
		case (idx)
			5'd0:    v = 32'd536870912;
			5'd1:    v = 32'd316933406;
			5'd2:    v = 32'd167458907;
			5'd3:    v = 32'd85004756;
			5'd4:    v = 32'd42667331;
			5'd5:    v = 32'd21354465;
			5'd6:    v = 32'd10679838;
			5'd7:    v = 32'd5340245;
			5'd8:    v = 32'd2670163;
			5'd9:    v = 32'd1335087;
			5'd10:   v = 32'd667544;
			5'd11:   v = 32'd333772;
			5'd12:   v = 32'd166886;
			5'd13:   v = 32'd83443;
			5'd14:   v = 32'd41722;
			5'd15:   v = 32'd20861;
			5'd16:   v = 32'd10430;
			5'd17:   v = 32'd5215;
			5'd18:   v = 32'd2608;
			5'd19:   v = 32'd1304;
			5'd20:   v = 32'd652;
			5'd21:   v = 32'd326;
			5'd22:   v = 32'd163;
			5'd23:   v = 32'd81;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

[rtl/lgpf_cordic.sv]
// Vectoring CORDIC, one micro-rotation per pipeline stage
module lgpf_cordic import lgpf_pkg::*; #(
	parameter int COEF_WIDTH    = COEF_WIDTH_DEF,
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic                          clk,
	input  logic                          adv,
	input  logic signed [COEF_WIDTH:0]    x_in,
	input  logic signed [COEF_WIDTH:0]    y_in,
	output logic [ANGLE_WIDTH-1:0]        angle
);
	localparam int W = COEF_WIDTH + 3;

	logic signed [W-1:0] x_s [0:CORDIC_STAGES];
	logic signed [W-1:0] y_s [0:CORDIC_STAGES];
	logic [31:0]         z_s [0:CORDIC_STAGES];
	logic [31:0]         z_round;

	// Quarter-turn pre-rotation into the right half plane
	always_ff @(posedge clk) begin
		if (adv) begin
			if (x_in < 0) begin
				if (y_in >= 0) begin
					x_s[0] <= W'(y_in);
					y_s[0] <= -W'(x_in);
					z_s[0] <= 32'h4000_0000;
				end else begin
					x_s[0] <= -W'(y_in);
					y_s[0] <= W'(x_in);
					z_s[0] <= 32'hC000_0000;
				end
			end else begin
				x_s[0] <= W'(x_in);
				y_s[0] <= W'(y_in);
				z_s[0] <= 32'h0;
			end
		end
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
		always_ff @(posedge clk) begin
			if (adv) begin
				if (y_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_lut(5'(i));
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_lut(5'(i));
				end
			end
		end
	end

	// Round half up to 16 bits
	assign z_round = z_s[CORDIC_STAGES] + 32'h8000;
	assign angle   = z_round[31:16];
endmodule

[rtl/lgpf_dist.sv]
// Distance: exact sum of squares, bit-serial square root and restoring
// divide, one result bit per pipeline stage
module lgpf_dist import lgpf_pkg::*; #(
	parameter int COEF_WIDTH    = COEF_WIDTH_DEF,
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic                      clk,
	input  logic                      adv,
	input  logic [COEF_WIDTH-1:0]     mag_a,
	input  logic [COEF_WIDTH-1:0]     mag_b,
	input  logic [COEF_WIDTH-1:0]     mag_c,
	output logic [DIST_WIDTH-1:0]     distance
);
	localparam int RW    = COEF_WIDTH;            // root width
	localparam int SW    = 2 * COEF_WIDTH + 1;    // sum of squares
	localparam int NW    = COEF_WIDTH + FRAC_BITS; // numerator width
	localparam int LAT   = CORDIC_STAGES + 1;
	localparam int USED  = 2 + RW + NW;           // stages of this path
	localparam int DLY   = (LAT > USED) ? LAT - USED : 0;

	// Squares, then sum
	logic [2*COEF_WIDTH-1:0] sqa_s1, sqb_s1;
	logic [COEF_WIDTH-1:0]   c_s1;
	logic [SW-1:0]           sum_s2;
	logic [COEF_WIDTH-1:0]   c_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			sqa_s1 <= mag_a * mag_a;
			sqb_s1 <= mag_b * mag_b;
			c_s1   <= mag_c;
			sum_s2 <= SW'(sqa_s1) + SW'(sqb_s1);
			c_s2   <= c_s1;
		end
	end

	// Non-restoring-free integer square root, one bit per stage
	logic [SW-1:0]         rem_r [0:RW];
	logic [RW-1:0]         root_r [0:RW];
	logic [COEF_WIDTH-1:0] c_r [0:RW];
	assign rem_r[0]  = sum_s2;
	assign root_r[0] = '0;
	assign c_r[0]    = c_s2;

	for (genvar k = 0; k < RW; k++) begin : g_sqrt
		localparam int B = RW - 1 - k;
		logic [RW-1:0]   t;
		logic [2*RW+1:0] tsq;
		logic [SW-1:0]   rem_q;
		logic [RW-1:0]   root_q;
		logic [COEF_WIDTH-1:0] c_q;
		// Trial bit test via (r+2^B)^2 = r^2 + r*2^(B+1) + 2^2B
		logic [2*RW+1:0] inc;
		assign t   = root_r[k] | (RW'(1) << B);
		assign inc = ((2*RW+2)'(root_r[k]) << (B + 1)) + ((2*RW+2)'(1) << (2 * B));
		assign tsq = inc;
		always_ff @(posedge clk) begin
			if (adv) begin
				if ((2*RW+2)'(rem_r[k]) >= tsq) begin
					rem_q  <= SW'((2*RW+2)'(rem_r[k]) - tsq);
					root_q <= t;
				end else begin
					rem_q  <= rem_r[k];
					root_q <= root_r[k];
				end
				c_q <= c_r[k];
			end
		end
		assign rem_r[k+1]  = rem_q;
		assign root_r[k+1] = root_q;
		assign c_r[k+1]    = c_q;
	end

	// Restoring division of |C|*2^16 by the root
	logic [NW-1:0] num_d [0:NW];
	logic [RW:0]   prem_d [0:NW];
	logic [NW-1:0] quo_d [0:NW];
	logic [RW-1:0] den_d [0:NW];
	assign num_d[0]  = {c_r[RW], FRAC_BITS'(0)};
	assign prem_d[0] = '0;
	assign quo_d[0]  = '0;
	assign den_d[0]  = (root_r[RW] == '0) ? RW'(1) : root_r[RW];

	for (genvar k = 0; k < NW; k++) begin : g_div
		logic [RW:0]   sh;
		logic [RW:0]   prem_q;
		logic [NW-1:0] quo_q, num_q;
		logic [RW-1:0] den_q;
		assign sh = {prem_d[k][RW-1:0], num_d[k][NW-1-k]};
		always_ff @(posedge clk) begin
			if (adv) begin
				if (sh >= {1'b0, den_d[k]}) begin
					prem_q <= sh - {1'b0, den_d[k]};
					quo_q  <= quo_d[k] | (NW'(1) << (NW - 1 - k));
				end else begin
					prem_q <= sh;
					quo_q  <= quo_d[k];
				end
				num_q <= num_d[k];
				den_q <= den_d[k];
			end
		end
		assign prem_d[k+1] = prem_q;
		assign quo_d[k+1]  = quo_q;
		assign num_d[k+1]  = num_q;
		assign den_d[k+1]  = den_q;
	end

	// Saturate
	logic [DIST_WIDTH-1:0] sat;
	always_comb begin
		if (NW > DIST_WIDTH && (quo_d[NW] >> DIST_WIDTH) != '0)
			sat = '1;
		else
			sat = DIST_WIDTH'(quo_d[NW]);
	end

	// Balance latency against the angle path
	logic [DIST_WIDTH-1:0] dl [0:DLY];
	assign dl[0] = sat;
	for (genvar k = 0; k < DLY; k++) begin : g_dly
		logic [DIST_WIDTH-1:0] d_q;
		always_ff @(posedge clk) if (adv) d_q <= dl[k];
		assign dl[k+1] = d_q;
	end
	assign distance = dl[DLY];
endmodule

[rtl/line_general_to_polar_form_unit.sv]
// Channel | valid    | stall     | payload
// in      | in_valid | in_stall  | coef_a, coef_b, coef_c
// out     | out_valid| out_stall | polar_angle, polar_distance, degenerate
//
// One transfer per cycle sustained unless out_stall holds a result. Pipeline depth is
// set by two square/sum stages, COEF_WIDTH square root stages and COEF_WIDTH+FRAC_BITS
// divider stages (one result bit per stage).
// arst_n clears the valid bits only; data registers carry no reset.
// The whole pipeline advances together; out_stall on a valid result freezes it,
// in_stall is high only while the last stage holds a result that cannot leave.
module line_general_to_polar_form_unit import lgpf_pkg::*; #(
	parameter int COEF_WIDTH    = COEF_WIDTH_DEF,
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COEF_WIDTH-1:0]  coef_a,
	input  logic signed [COEF_WIDTH-1:0]  coef_b,
	input  logic signed [COEF_WIDTH-1:0]  coef_c,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [ANGLE_WIDTH-1:0] polar_angle,
	output logic [DIST_WIDTH-1:0]         polar_distance,
	output logic                          degenerate
);
	localparam int LAT_ANG  = CORDIC_STAGES + 1;
	localparam int LAT_DIST = 2 + COEF_WIDTH + COEF_WIDTH + FRAC_BITS;
	localparam int LAT      = (LAT_ANG > LAT_DIST) ? LAT_ANG : LAT_DIST;
	localparam int ADLY     = LAT - LAT_ANG;

	logic adv;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// Orient the normal toward the line
	logic                       neg_c;
	logic signed [COEF_WIDTH:0] x0, y0;
	logic [COEF_WIDTH-1:0]      ma, mb, mc;
	assign neg_c = coef_c[COEF_WIDTH-1];
	assign x0 = neg_c ? (COEF_WIDTH+1)'(coef_a) : -(COEF_WIDTH+1)'(coef_a);
	assign y0 = neg_c ? (COEF_WIDTH+1)'(coef_b) : -(COEF_WIDTH+1)'(coef_b);
	assign ma = coef_a[COEF_WIDTH-1] ? COEF_WIDTH'(-coef_a) : COEF_WIDTH'(coef_a);
	assign mb = coef_b[COEF_WIDTH-1] ? COEF_WIDTH'(-coef_b) : COEF_WIDTH'(coef_b);
	assign mc = neg_c ? COEF_WIDTH'(-coef_c) : COEF_WIDTH'(coef_c);

	logic [ANGLE_WIDTH-1:0] ang_raw;
	logic [DIST_WIDTH-1:0]  dst_raw;

	lgpf_cordic #(.COEF_WIDTH(COEF_WIDTH), .CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
		.clk(clk), .adv(adv), .x_in(x0), .y_in(y0), .angle(ang_raw)
	);

	lgpf_dist #(.COEF_WIDTH(COEF_WIDTH), .CORDIC_STAGES(LAT - 1)) u_dist (
		.clk(clk), .adv(adv), .mag_a(ma), .mag_b(mb), .mag_c(mc), .distance(dst_raw)
	);

	// Delay the angle to match the distance path
	logic [ANGLE_WIDTH-1:0] ad [0:ADLY];
	assign ad[0] = ang_raw;
	for (genvar k = 0; k < ADLY; k++) begin : g_adly
		logic [ANGLE_WIDTH-1:0] a_q;
		always_ff @(posedge clk) if (adv) a_q <= ad[k];
		assign ad[k+1] = a_q;
	end

	// Valid and degenerate flags travel with the data
	logic vld_s [1:LAT];
	logic dgn_s [1:LAT];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= LAT; k++) vld_s[k] <= 1'b0;
		end else if (adv) begin
			vld_s[1] <= in_valid;
			for (int k = 2; k <= LAT; k++) vld_s[k] <= vld_s[k-1];
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			dgn_s[1] <= (coef_a == '0) && (coef_b == '0);
			for (int k = 2; k <= LAT; k++) dgn_s[k] <= dgn_s[k-1];
		end
	end

	assign out_valid      = vld_s[LAT];
	assign degenerate     = dgn_s[LAT];
	assign polar_angle    = dgn_s[LAT] ? '0 : ANGLE_WIDTH'(ad[ADLY]);
	assign polar_distance = dgn_s[LAT] ? '0 : dst_raw;

`ifndef NO_ASSERTIONS
	// A held result keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(polar_distance)
		&& $stable(polar_angle)) else $error("held result changed");
	// Input stalls only when output is blocked
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall) else $error("spurious stall");
	// Degenerate result carries zeros
	a_dgn: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> polar_distance == '0 && polar_angle == '0)
		else $error("degenerate payload nonzero");
`endif
endmodule

[sim/line_general_to_polar_form_checker.sv]
`timescale 1ns / 1ps
module line_general_to_polar_form_checker import lgpf_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic signed [31:0]            coef_a,
	input  logic signed [31:0]            coef_b,
	input  logic signed [31:0]            coef_c,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic signed [ANGLE_WIDTH-1:0] polar_angle,
	input  logic [DIST_WIDTH-1:0]         polar_distance,
	input  logic                          degenerate,
	output int                            fail_count,
	output int                            pending
);

	typedef struct packed {
		logic [15:0] angle;
		logic [31:0] distance;
		logic        degen;
	} polar_t;

	polar_t polar_expected_q[$];

	localparam logic [31:0] ATAN_TAB [24] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81};

	// Vectoring rotation: exact integer x/y, 32-bit wrapping angle
	function automatic logic [15:0] normal_angle(longint vx, longint vy);
		longint      x, y, t, dx, dy;
		logic [31:0] z;
		x = vx;
		y = vy;
		z = '0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; z = 32'h4000_0000;
			end else begin
				x = -y; y = t; z = 32'hC000_0000;
			end
		end
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += ATAN_TAB[i];
			end else begin
				x -= dx; y += dy; z -= ATAN_TAB[i];
			end
		end
		z = z + 32'h8000;
		return z[31:16];
	endfunction

	function automatic polar_t line_to_polar(longint a, longint b, longint c);
		polar_t           p;
		logic [127:0]     sq, tt;
		logic [63:0]      root, cand, quot;
		logic [63:0]      cmag;
		p = '0;
		if (a == 0 && b == 0) begin
			p.degen = 1'b1;
			return p;
		end
		p.angle = (c < 0) ? normal_angle(a, b) : normal_angle(-a, -b);
		sq = 128'(a * a) + 128'(b * b);
		root = '0;
		for (int bit_i = 48; bit_i >= 0; bit_i--) begin
			cand = root | (64'd1 << bit_i);
			tt = 128'(cand) * 128'(cand);
			if (tt <= sq)
				root = cand;
		end
		cmag = (c < 0) ? 64'(-c) : 64'(c);
		quot = (cmag << 16) / root;
		p.distance = (quot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
		return p;
	endfunction

	assign pending = polar_expected_q.size();

	// Predict on each input transfer, compare on each output transfer
	always @(posedge clk or negedge arst_n) begin
		polar_t e;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (in_valid && !in_stall)
				polar_expected_q.push_back(line_to_polar(coef_a, coef_b, coef_c));
			if (out_valid && !out_stall) begin
				if (polar_expected_q.size() == 0) begin
					$display("%0t: unexpected result angle=%0d dist=%h degen=%b", $time,
						polar_angle, polar_distance, degenerate);
					fail_count <= fail_count + 1;
				end else begin
					e = polar_expected_q.pop_front();
					if (e.angle !== polar_angle || e.distance !== polar_distance ||
							e.degen !== degenerate) begin
						$display("%0t: mismatch expected angle=%0d dist=%h degen=%b, %s",
							$time, $signed(e.angle), e.distance, e.degen, "got:");
						$display("%0t:          actual   angle=%0d dist=%h degen=%b",
							$time, polar_angle, polar_distance, degenerate);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

[sim/line_general_to_polar_form_unit_test.sv]
`timescale 1ns / 1ps
module line_general_to_polar_form_unit_test;
	import lgpf_pkg::*;

	localparam int LATENCY = 2 * 32 + 16 + 2;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic signed [31:0]            coef_a = '0, coef_b = '0, coef_c = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic signed [ANGLE_WIDTH-1:0] polar_angle;
	logic [DIST_WIDTH-1:0]         polar_distance;
	logic                          degenerate;
	int                            fail_count, pending;
	int                            cycle_count = 0;
	bit                            sink_hold = 1'b0;
	bit                            sink_free = 1'b0;

	always #5 clk = ~clk;

	line_general_to_polar_form_unit dut (.*);
	line_general_to_polar_form_checker polar_check (.*);

	// Abort on a hung pipeline
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 200000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Receiver: random stall per result, long hold-off on request
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (sink_hold) begin
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
				sink_hold = 1'b0;
			end
			gap = sink_free ? 0 : $urandom_range(0, 8);
			if (gap > 0 && $urandom_range(0, 3) != 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid || out_stall) @(posedge clk);
		end
	end

	function automatic logic [31:0] random_coef();
		case ($urandom_range(0, 5))
			0:       return $urandom;
			1:       return 32'($signed($urandom_range(0, 2000)) - 1000);
			2:       return 32'($signed($urandom_range(0, 32'h3FFFF)) - 32'h20000);
			3:       return 32'h8000_0000 | ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h0);
			4:       return '0;
			default: return $urandom >> $urandom_range(0, 31);
		endcase
	endfunction

	task automatic send_line(input logic [31:0] a, b, c, input bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 8);
		if (gap > 0 && $urandom_range(0, 3) != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		coef_a   <= a;
		coef_b   <= b;
		coef_c   <= c;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	localparam logic [31:0] MAXP = 32'h7FFF_FFFF;
	localparam logic [31:0] MINN = 32'h8000_0000;
	localparam logic [31:0] ONE  = 32'h0001_0000;

	initial begin
		logic [31:0] dir_a [] = '{0, 0, 0, ONE, -ONE, 0, 0, ONE, -ONE, -ONE, MAXP, MINN,
			MINN, MAXP, 1, 1, -1, ONE, 3, MINN, 32'hFFFF_FFFF, ONE, 0, 5, MAXP};
		logic [31:0] dir_b [] = '{0, 0, 0, 0, 0, ONE, -ONE, ONE, ONE, 0, MAXP, MINN,
			0, MINN, 0, 1, 0, 0, 4, MAXP, 32'hFFFF_FFFF, ONE, 1, 0, 0};
		logic [31:0] dir_c [] = '{0, MAXP, MINN, 0, ONE, -ONE, ONE, MINN, MAXP, -ONE,
			MINN, MAXP, -1, 1, MAXP, MINN, MINN, -ONE, 10, 0, MAXP, 0, MAXP, -5, -1};
		int burst;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, degenerate, C zero, angle of pi, saturation
		foreach (dir_a[i]) send_line(dir_a[i], dir_b[i], dir_c[i], 1'b0);

		// Fill the pipeline while the receiver holds off
		sink_hold = 1'b1;
		for (int i = 0; i < 150; i++)
			send_line(random_coef(), random_coef(), random_coef(), 1'b1);

		// Pause until drained
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);

		for (int i = 0; i < 525; i++) begin
			burst = $urandom_range(0, 9);
			sink_free = (burst == 0);
			send_line(random_coef(), random_coef(), random_coef(), burst < 2);
		end
		in_valid <= 1'b0;
		sink_free = 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[filelist.f]
rtl/lgpf_pkg.sv
rtl/lgpf_cordic.sv
rtl/lgpf_dist.sv
rtl/line_general_to_polar_form_unit.sv
sim/line_general_to_polar_form_checker.sv
sim/line_general_to_polar_form_unit_test.sv
